### src/brvm_pkg.sv
`timescale 1ns / 1ps

package brvm_pkg;

    localparam int MEM_BYTES = 8192;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int REG_COUNT = 256;
    localparam int REG_AW    = $clog2(REG_COUNT);

    localparam logic [15:0] CODE_WORDS_RST = 16'd256;

    localparam logic [7:0] OP_HALT   = 8'h00;
    localparam logic [7:0] OP_LOAD   = 8'h10;
    localparam logic [7:0] OP_STORE  = 8'h20;
    localparam logic [7:0] OP_MOVE   = 8'h30;
    localparam logic [7:0] OP_PUT    = 8'h40;
    localparam logic [7:0] OP_ADD    = 8'h50;
    localparam logic [7:0] OP_SUB    = 8'h60;
    localparam logic [7:0] OP_GT     = 8'h70;
    localparam logic [7:0] OP_GE     = 8'h80;
    localparam logic [7:0] OP_EQ     = 8'h90;
    localparam logic [7:0] OP_BRANCH = 8'hA0;
    localparam logic [7:0] OP_JUMP   = 8'hB0;

    localparam logic [1:0] FAULT_NONE   = 2'd0;
    localparam logic [1:0] FAULT_DATA   = 2'd1;
    localparam logic [1:0] FAULT_CODE   = 2'd2;
    localparam logic [1:0] FAULT_OPCODE = 2'd3;

    // pending or last register write, used for forwarding
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] idx;
        logic [31:0]       val;
    } t_fwd;

    typedef struct packed {
        logic              we;
        logic [REG_AW-1:0] idx;
        logic [31:0]       val;
        logic              load;
        logic [15:0]       next_pc;
        logic              halted;
        logic [1:0]        fault;
    } t_result;

    typedef struct packed {
        logic              re;
        logic              we;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_dmem_req;

    // port A: store address / branch test / first source
    function automatic logic [REG_AW-1:0] rf_addr_a(input logic [7:0] op,
                                                    input logic [7:0] b1,
                                                    input logic [7:0] b2);
        return (op == OP_STORE || op == OP_BRANCH) ? b1[REG_AW-1:0] : b2[REG_AW-1:0];
    endfunction

    // port B: store data / second source
    function automatic logic [REG_AW-1:0] rf_addr_b(input logic [7:0] op,
                                                    input logic [7:0] b2,
                                                    input logic [7:0] b3);
        return (op == OP_STORE) ? b2[REG_AW-1:0] : b3[REG_AW-1:0];
    endfunction

endpackage

### src/brvm_regfile.sv
`timescale 1ns / 1ps

module brvm_regfile (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_re,
    input  logic [brvm_pkg::REG_AW-1:0] i_raddr_a,
    input  logic [brvm_pkg::REG_AW-1:0] i_raddr_b,
    input  logic                        i_we,
    input  logic [brvm_pkg::REG_AW-1:0] i_waddr,
    input  logic [31:0]                 i_wdata,
    output logic [31:0]                 o_rdata_a,
    output logic [31:0]                 o_rdata_b
);

    logic [31:0]                    r_mem [brvm_pkg::REG_COUNT];
    logic [brvm_pkg::REG_COUNT-1:0] r_valid;
    logic [31:0]                    r_qa;
    logic [31:0]                    r_qb;
    logic                           r_va;
    logic                           r_vb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_qa <= r_mem[i_raddr_a];
            r_qb <= r_mem[i_raddr_b];
            r_va <= r_valid[i_raddr_a];
            r_vb <= r_valid[i_raddr_b];
        end
    end

    // an entry never written since reset reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    assign o_rdata_a = r_va ? r_qa : 32'd0;
    assign o_rdata_b = r_vb ? r_qb : 32'd0;

endmodule

### src/brvm_dmem.sv
`timescale 1ns / 1ps

### src/brvm_data_mem.sv
`timescale 1ns / 1ps

module brvm_data_mem (
    input  logic                i_clk,
    input  logic                i_en,
    input  brvm_pkg::t_dmem_req i_req,
    output logic [7:0]          o_rdata
);

    logic [7:0] r_mem [brvm_pkg::MEM_BYTES];
    logic [7:0] r_rdata;

    // single port: a word either loads or stores, never both
    always_ff @(posedge i_clk) begin
        if (i_en && i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_en && i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/brvm_execute.sv
`timescale 1ns / 1ps

module brvm_execute (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic [7:0]          i_opcode,
    input  logic [7:0]          i_dst,
    input  logic [7:0]          i_src_a,
    input  logic [7:0]          i_src_b,
    input  logic [31:0]         i_rdata_a,
    input  logic [31:0]         i_rdata_b,
    input  brvm_pkg::t_fwd      i_fwd_s3,
    input  brvm_pkg::t_fwd      i_fwd_wb,
    input  logic [15:0]         i_code_words,
    output brvm_pkg::t_result   o_result,
    output brvm_pkg::t_dmem_req o_dmem
);

    logic [15:0]                 r_pc;
    logic                        r_stopped;
    logic [15:0]                 n_pc;
    logic                        n_stopped;
    logic [brvm_pkg::REG_AW-1:0] idx_a;
    logic [brvm_pkg::REG_AW-1:0] idx_b;
    logic [31:0]                 opa;
    logic [31:0]                 opb;
    logic [1:0]                  fault_code;
    logic                        wr_en;
    logic [31:0]                 wr_val;
    logic                        is_load;
    logic [15:0]                 npc;
    logic                        stop_now;
    logic [15:0]                 tgt_dst;
    logic [15:0]                 tgt_a;
    logic [15:0]                 tgt_b;

    // newest value wins: word in the output stage, then last retired write
    function automatic logic [31:0] pick(input logic [brvm_pkg::REG_AW-1:0] idx,
                                         input logic [31:0]                 rdata,
                                         input brvm_pkg::t_fwd              s3,
                                         input brvm_pkg::t_fwd              wb);
        logic [31:0] v;
        if (s3.en && s3.idx == idx) begin
            v = s3.val;
        end else if (wb.en && wb.idx == idx) begin
            v = wb.val;
        end else begin
            v = rdata;
        end
        return v;
    endfunction

    assign idx_a   = brvm_pkg::rf_addr_a(i_opcode, i_dst, i_src_a);
    assign idx_b   = brvm_pkg::rf_addr_b(i_opcode, i_src_a, i_src_b);
    assign opa     = pick(idx_a, i_rdata_a, i_fwd_s3, i_fwd_wb);
    assign opb     = pick(idx_b, i_rdata_b, i_fwd_s3, i_fwd_wb);
    assign tgt_dst = {8'd0, i_dst};
    assign tgt_a   = {8'd0, i_src_a};
    assign tgt_b   = {8'd0, i_src_b};

    always_comb begin
        fault_code = brvm_pkg::FAULT_NONE;
        wr_en      = 1'b0;
        wr_val     = 32'd0;
        is_load    = 1'b0;
        npc        = r_pc + 16'd1;
        stop_now   = 1'b0;
        o_dmem     = '0;
        o_result   = '0;
        n_pc       = r_pc;
        n_stopped  = r_stopped;

        if (r_stopped) begin
            o_result.next_pc = r_pc;
            o_result.halted  = 1'b1;
        end else begin
            unique case (i_opcode)
                brvm_pkg::OP_HALT: begin
                    stop_now = 1'b1;
                    npc      = r_pc;
                end
                brvm_pkg::OP_LOAD: begin
                    if (opa >= 32'(brvm_pkg::MEM_BYTES)) begin
                        fault_code = brvm_pkg::FAULT_DATA;
                    end else begin
                        is_load     = 1'b1;
                        wr_en       = 1'b1;
                        o_dmem.re   = 1'b1;
                        o_dmem.addr = opa[brvm_pkg::MEM_AW-1:0];
                    end
                end
                brvm_pkg::OP_STORE: begin
                    if (opa >= 32'(brvm_pkg::MEM_BYTES)) begin
                        fault_code = brvm_pkg::FAULT_DATA;
                    end else begin
                        o_dmem.we    = 1'b1;
                        o_dmem.addr  = opa[brvm_pkg::MEM_AW-1:0];
                        o_dmem.wdata = opb[7:0];
                    end
                end
                brvm_pkg::OP_MOVE: begin
                    wr_en  = 1'b1;
                    wr_val = opa;
                end
                brvm_pkg::OP_PUT: begin
                    wr_en  = 1'b1;
                    wr_val = {24'd0, i_src_a};
                end
                brvm_pkg::OP_ADD: begin
                    wr_en  = 1'b1;
                    wr_val = opa + opb;
                end
                brvm_pkg::OP_SUB: begin
                    wr_en  = 1'b1;
                    wr_val = opa - opb;
                end
                brvm_pkg::OP_GT: begin
                    wr_en  = 1'b1;
                    wr_val = {31'd0, opa > opb};
                end
                brvm_pkg::OP_GE: begin
                    wr_en  = 1'b1;
                    wr_val = {31'd0, opa >= opb};
                end
                brvm_pkg::OP_EQ: begin
                    wr_en  = 1'b1;
                    wr_val = {31'd0, opa == opb};
                end
                brvm_pkg::OP_BRANCH: begin
                    // both targets checked, taken or not
                    if (tgt_a >= i_code_words || tgt_b >= i_code_words) begin
                        fault_code = brvm_pkg::FAULT_CODE;
                    end else begin
                        npc = (opa != 32'd0) ? tgt_a : tgt_b;
                    end
                end
                brvm_pkg::OP_JUMP: begin
                    if (tgt_dst >= i_code_words) begin
                        fault_code = brvm_pkg::FAULT_CODE;
                    end else begin
                        npc = tgt_dst;
                    end
                end
                default: begin
                    fault_code = brvm_pkg::FAULT_OPCODE;
                end
            endcase

            if (fault_code != brvm_pkg::FAULT_NONE) begin
                stop_now = 1'b1;
                npc      = r_pc;
                wr_en    = 1'b0;
                wr_val   = 32'd0;
                is_load  = 1'b0;
                o_dmem   = '0;
            end

            o_result.we      = wr_en;
            o_result.idx     = i_dst[brvm_pkg::REG_AW-1:0];
            o_result.val     = wr_val;
            o_result.load    = is_load;
            o_result.next_pc = npc;
            o_result.halted  = stop_now;
            o_result.fault   = fault_code;
            n_pc             = npc;
            n_stopped        = stop_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= 16'd0;
            r_stopped <= 1'b0;
        end else if (i_advance) begin
            r_pc      <= n_pc;
            r_stopped <= n_stopped;
        end
    end

endmodule

### src/byte_register_vm_executor.sv
`timescale 1ns / 1ps
// Channel  Valid        Stall        Payload
// in       i_in_valid   o_in_stall   i_opcode, i_dst_field, i_src_a_field, i_src_b_field
// out      o_out_valid  i_out_stall  o_next_pc, o_halted, o_fault, o_written_value
// cfg      i_cfg_we     -            i_cfg_data (code_words)
//
// One word per cycle sustained while the output is not stalled; a word is registered in
// the execute stage and its result in the output stage.
// The rate is set by the register file (two read ports, one write port) and the
// single-port data memory, each used once per word, with forwarding on the register file.
// Synchronous active-low reset clears pc, stop flag, register valid bits and the pipe;
// the data memory is not cleared.
// A stalled result holds the output stage; a new word is still taken while the
// execute stage is free.

module byte_register_vm_executor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_opcode,
    input  logic [7:0]  i_dst_field,
    input  logic [7:0]  i_src_a_field,
    input  logic [7:0]  i_src_b_field,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_next_pc,
    output logic        o_halted,
    output logic [1:0]  o_fault,
    output logic [31:0] o_written_value,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    logic                r_s2_v;
    logic [7:0]          r_s2_op;
    logic [7:0]          r_s2_dst;
    logic [7:0]          r_s2_src_a;
    logic [7:0]          r_s2_src_b;
    logic                r_s3_v;
    brvm_pkg::t_result   r_s3;
    brvm_pkg::t_fwd      r_wb;
    logic [15:0]         r_code_words;

    logic                s3_ready;
    logic                accept;
    logic                advance;
    logic                retire;
    logic [31:0]         rdata_a;
    logic [31:0]         rdata_b;
    logic [7:0]          dmem_rdata;
    logic [31:0]         s3_value;
    brvm_pkg::t_fwd      fwd_s3;
    brvm_pkg::t_result   ex_result;
    brvm_pkg::t_dmem_req dmem_req;

    assign s3_ready   = !r_s3_v || !i_out_stall;
    assign o_in_stall = r_s2_v && !s3_ready;
    assign accept     = i_in_valid && !o_in_stall;
    assign advance    = r_s2_v && s3_ready;
    assign retire     = r_s3_v && !i_out_stall;

    assign s3_value   = r_s3.load ? {24'd0, dmem_rdata} : r_s3.val;
    assign fwd_s3.en  = r_s3_v && r_s3.we;
    assign fwd_s3.idx = r_s3.idx;
    assign fwd_s3.val = s3_value;

    brvm_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_re      (accept),
        .i_raddr_a (brvm_pkg::rf_addr_a(i_opcode, i_dst_field, i_src_a_field)),
        .i_raddr_b (brvm_pkg::rf_addr_b(i_opcode, i_src_a_field, i_src_b_field)),
        .i_we      (retire && r_s3.we),
        .i_waddr   (r_s3.idx),
        .i_wdata   (s3_value),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    brvm_execute u_execute (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_opcode     (r_s2_op),
        .i_dst        (r_s2_dst),
        .i_src_a      (r_s2_src_a),
        .i_src_b      (r_s2_src_b),
        .i_rdata_a    (rdata_a),
        .i_rdata_b    (rdata_b),
        .i_fwd_s3     (fwd_s3),
        .i_fwd_wb     (r_wb),
        .i_code_words (r_code_words),
        .o_result     (ex_result),
        .o_dmem       (dmem_req)
    );

    brvm_data_mem u_data_mem (
        .i_clk   (i_clk),
        .i_en    (advance),
        .i_req   (dmem_req),
        .o_rdata (dmem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v       <= 1'b0;
            r_s3_v       <= 1'b0;
            r_wb.en      <= 1'b0;
            r_code_words <= brvm_pkg::CODE_WORDS_RST;
        end else begin
            if (accept) begin
                r_s2_v <= 1'b1;
            end else if (advance) begin
                r_s2_v <= 1'b0;
            end
            if (advance) begin
                r_s3_v <= 1'b1;
            end else if (retire) begin
                r_s3_v <= 1'b0;
            end
            // last retired write stays until the next one; it matches the array
            if (retire && r_s3.we) begin
                r_wb.en  <= 1'b1;
                r_wb.idx <= r_s3.idx;
                r_wb.val <= s3_value;
            end
            if (i_cfg_we) begin
                r_code_words <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_op    <= i_opcode;
            r_s2_dst   <= i_dst_field;
            r_s2_src_a <= i_src_a_field;
            r_s2_src_b <= i_src_b_field;
        end
        if (advance) begin
            r_s3 <= ex_result;
        end
    end

    assign o_out_valid     = r_s3_v;
    assign o_next_pc       = r_s3.next_pc;
    assign o_halted        = r_s3.halted;
    assign o_fault         = r_s3.fault;
    assign o_written_value = s3_value;

endmodule

### src/brvm_checker.sv
`timescale 1ns / 1ps

module brvm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_next_pc,
    input logic        o_halted,
    input logic [1:0]  o_fault,
    input logic [31:0] o_written_value
);

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_next_pc) && $stable(o_written_value)
            && $stable(o_fault) && $stable(o_halted))
        else $error("output word changed while stalled");

    a_fault_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fault != brvm_pkg::FAULT_NONE |-> o_halted)
        else $error("fault reported without halt");

    a_fault_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fault != brvm_pkg::FAULT_NONE |-> o_written_value == 32'd0)
        else $error("faulting word reports a register write");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

endmodule

bind byte_register_vm_executor brvm_checker u_brvm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_next_pc       (o_next_pc),
    .o_halted        (o_halted),
    .o_fault         (o_fault),
    .o_written_value (o_written_value)
);

### test/tb_byte_register_vm_executor.sv
`timescale 1ns / 1ps

module tb_byte_register_vm_executor;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        halted;
        logic [1:0]  fault;
        logic [31:0] written_value;
    } t_vm_outcome;

    class vm_scoreboard;
        bit [31:0]   regs [brvm_pkg::REG_COUNT];
        bit [7:0]    mem [brvm_pkg::MEM_BYTES];
        bit          mem_set [brvm_pkg::MEM_BYTES];
        bit [15:0]   pc;
        bit          stopped;
        bit [15:0]   code_words = brvm_pkg::CODE_WORDS_RST;
        t_vm_outcome awaited_outcomes [$];
        int          errors;
        int          words;
        int          results;

        // executes one accepted word on the shadow machine and queues its outcome
        function void note_word(input logic [7:0] op, input logic [7:0] b1,
                                input logic [7:0] b2, input logic [7:0] b3);
            t_vm_outcome outcome;
            bit [31:0]   addr;
            bit [31:0]   w;
            bit [15:0]   npc;
            bit [1:0]    f;
            words++;
            if (stopped) begin
                outcome = '{pc, 1'b1, brvm_pkg::FAULT_NONE, 32'd0};
                awaited_outcomes.push_back(outcome);
                return;
            end
            npc = pc + 16'd1;
            f   = brvm_pkg::FAULT_NONE;
            w   = '0;
            case (op)
                brvm_pkg::OP_HALT: begin
                    stopped = 1'b1;
                    npc     = pc;
                end
                brvm_pkg::OP_LOAD: begin
                    addr = regs[b2];
                    if (addr >= brvm_pkg::MEM_BYTES) begin
                        f = brvm_pkg::FAULT_DATA;
                    end else begin
                        w = {24'd0, mem[addr[brvm_pkg::MEM_AW-1:0]]};
                        regs[b1] = w;
                    end
                end
                brvm_pkg::OP_STORE: begin
                    addr = regs[b1];
                    if (addr >= brvm_pkg::MEM_BYTES) begin
                        f = brvm_pkg::FAULT_DATA;
                    end else begin
                        mem[addr[brvm_pkg::MEM_AW-1:0]]     = regs[b2][7:0];
                        mem_set[addr[brvm_pkg::MEM_AW-1:0]] = 1'b1;
                    end
                end
                brvm_pkg::OP_MOVE: begin
                    w = regs[b2];
                    regs[b1] = w;
                end
                brvm_pkg::OP_PUT: begin
                    w = {24'd0, b2};
                    regs[b1] = w;
                end
                brvm_pkg::OP_ADD: begin
                    w = regs[b2] + regs[b3];
                    regs[b1] = w;
                end
                brvm_pkg::OP_SUB: begin
                    w = regs[b2] - regs[b3];
                    regs[b1] = w;
                end
                brvm_pkg::OP_GT: begin
                    w = (regs[b2] > regs[b3]) ? 32'd1 : 32'd0;
                    regs[b1] = w;
                end
                brvm_pkg::OP_GE: begin
                    w = (regs[b2] >= regs[b3]) ? 32'd1 : 32'd0;
                    regs[b1] = w;
                end
                brvm_pkg::OP_EQ: begin
                    w = (regs[b2] == regs[b3]) ? 32'd1 : 32'd0;
                    regs[b1] = w;
                end
                brvm_pkg::OP_BRANCH: begin
                    // both targets are checked, whichever one is taken
                    if ({8'd0, b2} >= code_words || {8'd0, b3} >= code_words)
                        f = brvm_pkg::FAULT_CODE;
                    else
                        npc = (regs[b1] != 0) ? {8'd0, b2} : {8'd0, b3};
                end
                brvm_pkg::OP_JUMP: begin
                    if ({8'd0, b1} >= code_words)
                        f = brvm_pkg::FAULT_CODE;
                    else
                        npc = {8'd0, b1};
                end
                default: f = brvm_pkg::FAULT_OPCODE;
            endcase
            if (f != brvm_pkg::FAULT_NONE) begin
                stopped = 1'b1;
                npc     = pc;
                w       = '0;
            end
            pc = npc;
            outcome = '{npc, stopped, f, w};
            awaited_outcomes.push_back(outcome);
        endfunction

        function void check_result(input t_vm_outcome got);
            t_vm_outcome exp;
            results++;
            if (awaited_outcomes.size() == 0) begin
                $error("unexpected result word: next_pc %0h written_value %0h",
                       got.next_pc, got.written_value);
                errors++;
                return;
            end
            exp = awaited_outcomes.pop_front();
            if (got.next_pc !== exp.next_pc) begin
                $error("next_pc: expected %0h, actual %0h", exp.next_pc, got.next_pc);
                errors++;
            end
            if (got.halted !== exp.halted) begin
                $error("halted: expected %0b, actual %0b", exp.halted, got.halted);
                errors++;
            end
            if (got.fault !== exp.fault) begin
                $error("fault: expected %0d, actual %0d", exp.fault, got.fault);
                errors++;
            end
            if (got.written_value !== exp.written_value) begin
                $error("written_value: expected %0h, actual %0h",
                       exp.written_value, got.written_value);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_opcode        = '0;
    logic [7:0]  i_dst_field     = '0;
    logic [7:0]  i_src_a_field   = '0;
    logic [7:0]  i_src_b_field   = '0;
    logic        o_out_valid;
    logic        i_out_stall     = 1'b0;
    logic [15:0] o_next_pc;
    logic        o_halted;
    logic [1:0]  o_fault;
    logic [31:0] o_written_value;
    logic        i_cfg_we        = 1'b0;
    logic [15:0] i_cfg_data      = '0;

    vm_scoreboard sb;
    bit           quiet;
    bit           hold_req;
    int           cw_writes;
    string        stop_how;

    byte_register_vm_executor i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_dst_field     (i_dst_field),
        .i_src_a_field   (i_src_a_field),
        .i_src_b_field   (i_src_b_field),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_next_pc       (o_next_pc),
        .o_halted        (o_halted),
        .o_fault         (o_fault),
        .o_written_value (o_written_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    // result side: checks accepted words and drives the stall
    initial begin
        t_vm_outcome got;
        int          hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
                got = '{o_next_pc, o_halted, o_fault, o_written_value};
                sb.check_result(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 59;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !quiet && ($urandom_range(99) < 21);
            end
        end
    end

    task automatic send_word(input logic [7:0] op, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3);
        while (!quiet && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_dst_field   <= b1;
        i_src_a_field <= b2;
        i_src_b_field <= b3;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        sb.note_word(op, b1, b2, b3);
    endtask

    task automatic drain_outcomes();
        i_in_valid <= 1'b0;
        while (sb.awaited_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_code_words(input logic [15:0] v);
        drain_outcomes();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.code_words = v;
        cw_writes++;
    endtask

    function automatic logic [7:0] pick_reg();
        return 8'($urandom_range(255));
    endfunction

    function automatic bit is_opcode(input logic [7:0] op);
        return op[3:0] == 4'd0 && op <= brvm_pkg::OP_JUMP;
    endfunction

    // register holding an in-range address, optionally one already stored to
    function automatic int find_ptr(input bit need_data);
        int r;
        for (int t = 0; t < 48; t++) begin
            r = $urandom_range(255);
            if (sb.regs[r] < brvm_pkg::MEM_BYTES &&
                (!need_data || sb.mem_set[sb.regs[r][brvm_pkg::MEM_AW-1:0]]))
                return r;
        end
        return -1;
    endfunction

    // build an address by doubling a small immediate, store through it, read it back
    task automatic pointer_walk();
        logic [7:0] p;
        int         shifts;
        p      = pick_reg();
        shifts = $urandom_range(5);
        send_word(brvm_pkg::OP_PUT, p, 8'($urandom_range(255)), pick_reg());
        repeat (shifts) send_word(brvm_pkg::OP_ADD, p, p, p);
        send_word(brvm_pkg::OP_STORE, p, pick_reg(), pick_reg());
        send_word(brvm_pkg::OP_LOAD, pick_reg(), p, pick_reg());
    endtask

    task automatic random_word();
        int         pick;
        int         r;
        int         lim;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] op;
        pick = $urandom_range(99);
        a    = pick_reg();
        b    = ($urandom_range(3) == 0) ? a : pick_reg();
        lim  = (sb.code_words > 256) ? 255 : int'(sb.code_words) - 1;
        if (pick < 14) begin
            send_word(brvm_pkg::OP_PUT, pick_reg(), 8'($urandom_range(255)), pick_reg());
        end else if (pick < 32) begin
            send_word($urandom_range(1) ? brvm_pkg::OP_ADD : brvm_pkg::OP_SUB,
                      pick_reg(), a, b);
        end else if (pick < 48) begin
            case ($urandom_range(2))
                0:       op = brvm_pkg::OP_GT;
                1:       op = brvm_pkg::OP_GE;
                default: op = brvm_pkg::OP_EQ;
            endcase
            send_word(op, pick_reg(), a, b);
        end else if (pick < 56) begin
            send_word(brvm_pkg::OP_MOVE, pick_reg(), a, pick_reg());
        end else if (pick < 68) begin
            r = find_ptr(1'b0);
            if (r < 0)
                pointer_walk();
            else
                send_word(brvm_pkg::OP_STORE, 8'(r), pick_reg(), pick_reg());
        end else if (pick < 78) begin
            r = find_ptr(1'b1);
            if (r < 0)
                pointer_walk();
            else
                send_word(brvm_pkg::OP_LOAD, pick_reg(), 8'(r), pick_reg());
        end else if (pick < 86) begin
            pointer_walk();
        end else if (pick < 94) begin
            send_word(brvm_pkg::OP_BRANCH, pick_reg(), 8'($urandom_range(lim)),
                      8'($urandom_range(lim)));
        end else begin
            send_word(brvm_pkg::OP_JUMP, 8'($urandom_range(lim)), pick_reg(), pick_reg());
        end
    endtask

    task automatic directed_words();
        send_word(brvm_pkg::OP_PUT, 8'd1, 8'hFF, 8'h00);
        send_word(brvm_pkg::OP_PUT, 8'd3, 8'h01, 8'hFF);
        send_word(brvm_pkg::OP_SUB, 8'd4, 8'd0, 8'd3);      // wraps to all ones
        send_word(brvm_pkg::OP_SUB, 8'd2, 8'd0, 8'd1);
        send_word(brvm_pkg::OP_ADD, 8'd5, 8'd4, 8'd3);      // wraps to zero
        send_word(brvm_pkg::OP_ADD, 8'd6, 8'd4, 8'd4);
        send_word(brvm_pkg::OP_GT, 8'd7, 8'd4, 8'd6);
        send_word(brvm_pkg::OP_GT, 8'd8, 8'd0, 8'd4);
        send_word(brvm_pkg::OP_GE, 8'd9, 8'd1, 8'd1);
        send_word(brvm_pkg::OP_EQ, 8'd10, 8'd4, 8'd2);
        send_word(brvm_pkg::OP_MOVE, 8'd255, 8'd4, 8'h5A);
        send_word(brvm_pkg::OP_STORE, 8'd0, 8'd255, 8'hA5); // lowest address
        send_word(brvm_pkg::OP_LOAD, 8'd11, 8'd0, 8'hFF);
        repeat (5) send_word(brvm_pkg::OP_ADD, 8'd1, 8'd1, 8'd1);
        send_word(brvm_pkg::OP_PUT, 8'd12, 8'd31, 8'h00);
        send_word(brvm_pkg::OP_ADD, 8'd12, 8'd1, 8'd12);    // top address of data memory
        send_word(brvm_pkg::OP_STORE, 8'd12, 8'd2, 8'h00);
        send_word(brvm_pkg::OP_LOAD, 8'd13, 8'd12, 8'h00);
        send_word(brvm_pkg::OP_BRANCH, 8'd4, 8'd255, 8'd0);
        send_word(brvm_pkg::OP_BRANCH, 8'd0, 8'd7, 8'd255);
        send_word(brvm_pkg::OP_JUMP, 8'd0, 8'hFF, 8'hFF);
        send_word(brvm_pkg::OP_JUMP, 8'd255, 8'h00, 8'h00);
    endtask

    // stopping is permanent without a reset, so it happens once, at the end
    task automatic stop_block(output string how);
        int         lim;
        logic [7:0] op;
        logic [7:0] bad;
        logic [7:0] good;
        case ($urandom_range(3))
            0: begin
                how = "halt";
                send_word(brvm_pkg::OP_HALT, pick_reg(), pick_reg(), pick_reg());
            end
            1: begin
                how = "a data address fault";
                // first address past the end of data memory
                send_word(brvm_pkg::OP_PUT, 8'd252, 8'd128, pick_reg());
                repeat (6) send_word(brvm_pkg::OP_ADD, 8'd252, 8'd252, 8'd252);
                if ($urandom_range(1))
                    send_word(brvm_pkg::OP_LOAD, pick_reg(), 8'd252, pick_reg());
                else
                    send_word(brvm_pkg::OP_STORE, 8'd252, pick_reg(), pick_reg());
            end
            2: begin
                how = "a code target fault";
                if ($urandom_range(1))
                    write_code_words(16'd0);
                else
                    write_code_words(16'($urandom_range(1, 255)));
                lim  = sb.code_words;
                bad  = 8'($urandom_range(255, lim));
                good = pick_reg();
                if ($urandom_range(2) == 0)
                    send_word(brvm_pkg::OP_JUMP, bad, pick_reg(), pick_reg());
                else if ($urandom_range(1))
                    send_word(brvm_pkg::OP_BRANCH, pick_reg(), bad, good);
                else
                    send_word(brvm_pkg::OP_BRANCH, pick_reg(), good, bad);
            end
            default: begin
                how = "an illegal opcode";
                case ($urandom_range(3))
                    0: op = 8'hC0;
                    1: op = 8'hD0;
                    default: begin
                        op = 8'($urandom_range(255));
                        while (is_opcode(op))
                            op = 8'($urandom_range(255));
                    end
                endcase
                send_word(op, pick_reg(), pick_reg(), pick_reg());
            end
        endcase
        // once stopped, any word is ignored
        repeat (12)
            send_word(8'($urandom_range(255)), pick_reg(), pick_reg(), pick_reg());
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_words();
        hold_req = 1'b1;            // long back-pressure while words keep coming
        repeat (110) random_word();
        drain_outcomes();           // sender pauses until everything is back
        repeat (110) random_word();

        write_code_words(16'd1);
        repeat (140) random_word();
        write_code_words(16'hFFFF);
        quiet = 1'b1;
        repeat (180) random_word();
        quiet = 1'b0;
        write_code_words(16'($urandom_range(300, 2)));
        repeat (140) random_word();
        write_code_words(16'($urandom_range(65535, 1)));
        repeat (140) random_word();

        stop_block(stop_how);
        drain_outcomes();
        repeat (6) @(posedge i_clk);

        $display("Sent %0d words over %0d code_words settings, compared %0d results.",
                 sb.words, cw_writes + 1, sb.results);
        $display("Run ended with the block stopped by %s; %0d mismatches.",
                 stop_how, sb.errors);
        if (sb.errors == 0 && sb.awaited_outcomes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
